### hw/rtl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared types and constants of the HSL to RGB color converter pipeline.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	// fixed-point format of saturation and lightness
	localparam int FRAC_BITS = 12;
	localparam int SL_W      = FRAC_BITS + 1;
	localparam logic [SL_W-1:0] SL_ONE = SL_W'(1 << FRAC_BITS);

	// hue in 1/16 degree, 960 units per 60-degree sector
	localparam int HUE_W        = 16;
	localparam int SECTOR_UNITS = 960;
	localparam int HUE_LIMIT    = 6 * SECTOR_UNITS;
	localparam int OFF_W        = 10;
	localparam int SEC_W        = 3;

	// signed sector weight, k - 480 with k in 0..960
	localparam int COEF_W = OFF_W + 1;

	// chroma with 2*FRAC_BITS fraction bits, at most 1.0
	localparam int C2_W = 2 * FRAC_BITS + 1;

	// channel value in units of 1 / (960 * 2^(2*FRAC_BITS)), at most 960 * 2^(2*FRAC_BITS)
	localparam int V_W = 2 * FRAC_BITS + 10;

	localparam int CH_W = 8;

	// 60-degree hue sectors
	typedef enum logic [SEC_W-1:0] {
		SEC_R2Y = 3'd0,
		SEC_Y2G = 3'd1,
		SEC_G2C = 3'd2,
		SEC_C2B = 3'd3,
		SEC_B2M = 3'd4,
		SEC_M2R = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SL_W-1:0]  saturation;
		logic [SL_W-1:0]  lightness;
	} hsl_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// after decode
	typedef struct packed {
		logic [SL_W-1:0]  sat;
		logic [SL_W-1:0]  lit;
		logic [SL_W-1:0]  span;
		sector_t          sector;
		logic [OFF_W-1:0] off;
		logic             in_range;
	} s1_t;

	// after chroma and sector weights
	typedef struct packed {
		logic [C2_W-1:0]          c2;
		logic [SL_W-1:0]          lit;
		logic signed [COEF_W-1:0] coef_r;
		logic signed [COEF_W-1:0] coef_g;
		logic signed [COEF_W-1:0] coef_b;
	} s2_t;

	// after blend, exact channel values
	typedef struct packed {
		logic [V_W-1:0] v_r;
		logic [V_W-1:0] v_g;
		logic [V_W-1:0] v_b;
	} s3_t;

endpackage

### hw/rtl/hsl_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_unit
// Four-stage pipelined HSL to 8-bit RGB color converter.
// ----------------------------------------------------------------------------
// takes one hsl word per clock and returns one rgb word per clock when
// nothing stalls. hue is in 1/16 degree (5760 and above gives grey),
// saturation and lightness are unsigned with 12 fraction bits and are
// clamped to 1.0. the pipeline is decode, chroma and sector weights,
// blend, then scale by 255 with truncation; the result is exact up to
// that final truncation. each stage has its own valid bit and moves
// when the stage after it is empty or moving, so bubbles are squeezed
// out and up to four words are held while rgb_stall is high. hsl_stall
// rises only when all four stages hold a word and the output is stalled.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit
	import hsl2rgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic hsl_valid,
	output logic hsl_stall,
	input  hsl_t hsl,
	output logic rgb_valid,
	input  logic rgb_stall,
	output rgb_t rgb
);

	// stage valid bits
	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic v4_q;

	// stage advance enables, back to front
	logic en1;
	logic en2;
	logic en3;
	logic en4;

	// stage payloads
	s1_t s1;
	s2_t s2;
	s3_t s3;

	assign en4 = !v4_q || !rgb_stall;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;

	assign hsl_stall = !en1;
	assign rgb_valid = v4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= hsl_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en4) begin
				v4_q <= v3_q;
			end
		end
	end

	// clamp, span and hue sector
	hsl2rgb_decode u_decode (
		.clk (clk),
		.en  (en1),
		.hsl (hsl),
		.s1  (s1)
	);

	// chroma and per-channel weights
	hsl2rgb_coef u_coef (
		.clk (clk),
		.en  (en2),
		.s1  (s1),
		.s2  (s2)
	);

	// exact channel values
	hsl2rgb_blend u_blend (
		.clk (clk),
		.en  (en3),
		.s2  (s2),
		.s3  (s3)
	);

	// scale to 8 bits, output register
	hsl2rgb_scale u_scale (
		.clk (clk),
		.en  (en4),
		.s3  (s3),
		.rgb (rgb)
	);

	// input is held off only with every stage full and the output stalled
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_stall |-> (v1_q && v2_q && v3_q && v4_q && rgb_stall))
		else $error("input stalled while the pipeline has room");

	// a word in the blend stage reaches the output when the last stage moves
	a_blend_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && en4) |=> rgb_valid)
		else $error("word lost between blend and output");

	// decoded sector of an in-range hue is one of the six
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && s1.in_range) |-> (s1.sector <= SEC_M2R && s1.off < OFF_W'(SECTOR_UNITS)))
		else $error("hue decode out of range");

endmodule

### hw/rtl/hsl2rgb_decode.sv
// ----------------------------------------------------------------------------
// hsl2rgb_decode
// First stage: clamps saturation and lightness, forms 1 - |2L - 1| and
// splits the hue into sector and offset within the sector.
// ----------------------------------------------------------------------------
module hsl2rgb_decode
	import hsl2rgb_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  hsl_t hsl,
	output s1_t  s1
);

	localparam logic [SL_W:0] TWOL_ONE = (SL_W + 1)'(1 << FRAC_BITS);
	localparam logic [SL_W:0] TWOL_TWO = (SL_W + 1)'(1 << (FRAC_BITS + 1));

	logic [SL_W-1:0]  sat_c;
	logic [SL_W-1:0]  lit_c;
	logic [SL_W:0]    twol;
	logic [SL_W:0]    span_w;
	logic [SEC_W-1:0] sec_idx;
	logic [HUE_W-1:0] base;
	s1_t              s1_d;

	always_comb begin
		sat_c = (hsl.saturation > SL_ONE) ? SL_ONE : hsl.saturation;
		lit_c = (hsl.lightness > SL_ONE) ? SL_ONE : hsl.lightness;
		twol = {lit_c, 1'b0};
		span_w = (twol >= TWOL_ONE) ? (TWOL_TWO - twol) : twol;

		// sector by compare against the sector boundaries
		sec_idx = '0;
		for (int i = 1; i < 6; i++) begin
			if (hsl.hue >= HUE_W'(i * SECTOR_UNITS)) begin
				sec_idx = SEC_W'(i);
			end
		end
		base = HUE_W'(SECTOR_UNITS) * HUE_W'(sec_idx);

		s1_d.sat      = sat_c;
		s1_d.lit      = lit_c;
		s1_d.span     = span_w[SL_W-1:0];
		s1_d.sector   = sector_t'(sec_idx);
		s1_d.off      = OFF_W'(hsl.hue - base);
		s1_d.in_range = (hsl.hue < HUE_W'(HUE_LIMIT));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1 <= s1_d;
		end
	end

endmodule

### hw/rtl/hsl2rgb_coef.sv
// ----------------------------------------------------------------------------
// hsl2rgb_coef
// Second stage: chroma product and the signed weight of each channel,
// chosen by hue sector.
// ----------------------------------------------------------------------------
module hsl2rgb_coef
	import hsl2rgb_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  s1_t  s1,
	output s2_t  s2
);

	localparam logic signed [COEF_W-1:0] C_FULL = COEF_W'(SECTOR_UNITS / 2);
	localparam logic signed [COEF_W-1:0] C_NONE = -C_FULL;
	localparam logic signed [COEF_W-1:0] C_GREY = -C_FULL;

	logic [2*SL_W-1:0]        prod;
	logic [OFF_W-1:0]         d;
	logic signed [COEF_W-1:0] c_x;
	s2_t                      s2_d;

	always_comb begin
		prod = (2 * SL_W)'(s1.span) * (2 * SL_W)'(s1.sat);

		// distance along the ramp: rising in even sectors, falling in odd ones
		d = s1.sector[0] ? (OFF_W'(SECTOR_UNITS) - s1.off) : s1.off;
		c_x = $signed({1'b0, d}) - C_FULL;

		s2_d.c2  = prod[C2_W-1:0];
		s2_d.lit = s1.lit;
		unique case (s1.sector)
			SEC_R2Y: begin
				s2_d.coef_r = C_FULL; s2_d.coef_g = c_x;    s2_d.coef_b = C_NONE;
			end
			SEC_Y2G: begin
				s2_d.coef_r = c_x;    s2_d.coef_g = C_FULL; s2_d.coef_b = C_NONE;
			end
			SEC_G2C: begin
				s2_d.coef_r = C_NONE; s2_d.coef_g = C_FULL; s2_d.coef_b = c_x;
			end
			SEC_C2B: begin
				s2_d.coef_r = C_NONE; s2_d.coef_g = c_x;    s2_d.coef_b = C_FULL;
			end
			SEC_B2M: begin
				s2_d.coef_r = c_x;    s2_d.coef_g = C_NONE; s2_d.coef_b = C_FULL;
			end
			default: begin
				s2_d.coef_r = C_FULL; s2_d.coef_g = C_NONE; s2_d.coef_b = c_x;
			end
		endcase

		// out-of-range hue leaves only the grey offset
		if (!s1.in_range) begin
			s2_d.coef_r = C_GREY;
			s2_d.coef_g = C_GREY;
			s2_d.coef_b = C_GREY;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2 <= s2_d;
		end
	end

endmodule

### hw/rtl/hsl2rgb_blend.sv
// ----------------------------------------------------------------------------
// hsl2rgb_blend
// Third stage: each channel as 960 * L * 2^F + chroma * weight, exact.
// ----------------------------------------------------------------------------
module hsl2rgb_blend
	import hsl2rgb_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  s2_t  s2,
	output s3_t  s3
);

	localparam int P_W = C2_W + 1 + COEF_W;

	function automatic logic [V_W-1:0] blend(
		input logic [V_W-1:0]          b,
		input logic [C2_W-1:0]         c,
		input logic signed [COEF_W-1:0] k
	);
		logic signed [P_W-1:0] pr;
		logic signed [P_W-1:0] sum;
		pr = P_W'($signed({1'b0, c})) * P_W'(k);
		sum = $signed(P_W'(b)) + pr;
		return sum[V_W-1:0];
	endfunction

	logic [V_W-1:0] base;
	s3_t            s3_d;

	always_comb begin
		base = (V_W'(s2.lit) * V_W'(SECTOR_UNITS)) << FRAC_BITS;
		s3_d.v_r = blend(base, s2.c2, s2.coef_r);
		s3_d.v_g = blend(base, s2.c2, s2.coef_g);
		s3_d.v_b = blend(base, s2.c2, s2.coef_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s3 <= s3_d;
		end
	end

endmodule

### hw/rtl/hsl2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsl2rgb_scale
// Last stage: scales by 255/960 = 17/64, drops the fraction and clamps.
// ----------------------------------------------------------------------------
module hsl2rgb_scale
	import hsl2rgb_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  s3_t  s3,
	output rgb_t rgb
);

	localparam int T_W  = V_W + 5;
	localparam int SH   = 2 * FRAC_BITS + 6;
	localparam int Q_W  = T_W - SH;
	localparam logic [Q_W-1:0] Q_MAX = Q_W'((1 << CH_W) - 1);

	function automatic logic [CH_W-1:0] to_ch(input logic [V_W-1:0] v);
		logic [T_W-1:0] t;
		logic [Q_W-1:0] q;
		t = (T_W'(v) << 4) + T_W'(v);
		q = t[T_W-1:SH];
		return (q > Q_MAX) ? CH_W'(Q_MAX) : q[CH_W-1:0];
	endfunction

	rgb_t rgb_d;

	always_comb begin
		rgb_d.red   = to_ch(s3.v_r);
		rgb_d.green = to_ch(s3.v_g);
		rgb_d.blue  = to_ch(s3.v_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb <= rgb_d;
		end
	end

endmodule
